>>> design/rmms_pkg.sv
package rmms_pkg;

	localparam int MAX_COLS_DEF = 2048;
	localparam int MAX_ROWS_DEF = 2048;

	localparam int PIX_W   = 8;
	localparam int COORD_W = 11;
	localparam int COUNT_W = 23;
	localparam int SUM_W   = 34;
	localparam int PCT_W   = 7;

	// rectangle extent holds up to 2048, one bit above a coordinate
	localparam int EXT_W    = COORD_W + 1;
	localparam int AREA_W   = 2 * EXT_W;
	localparam int PROD_W   = AREA_W + PCT_W;
	localparam int CNT100_W = COUNT_W + PCT_W;
	localparam logic [PCT_W-1:0] PERCENT_SCALE = 7'd100;

	localparam int QUEUE_DEPTH = 2;

	localparam int REG_ADDR_W = 5;
	localparam int REG_IDX_W  = 3;
	localparam logic [REG_IDX_W-1:0] REG_ROI_LEFT       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ROI_TOP        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROI_RIGHT      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ROI_BOTTOM     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DIFF_THRESHOLD = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MIN_PERCENT    = 3'd5;

	typedef struct packed {
		logic [PIX_W-1:0] prev_pixel;
		logic [PIX_W-1:0] cur_pixel;
		logic             end_of_line;
		logic             end_of_frame;
	} pix_t;

	typedef struct packed {
		logic               motion_found;
		logic [COUNT_W-1:0] moving_count;
		logic [COORD_W-1:0] centroid_x;
		logic [COORD_W-1:0] centroid_y;
		logic               centroid_valid;
	} res_t;

	typedef struct packed {
		logic [COORD_W-1:0] roi_left;
		logic [COORD_W-1:0] roi_top;
		logic [COORD_W-1:0] roi_right;
		logic [COORD_W-1:0] roi_bottom;
		logic [PIX_W-1:0]   diff_threshold;
		logic [PCT_W-1:0]   min_percent;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   col_sum;
		logic [SUM_W-1:0]   row_sum;
	} frame_rec_t;

endpackage

>>> design/rmms_front.sv
module rmms_front import rmms_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pix_valid,
	output logic       pix_ready,
	input  pix_t       pix,
	input  cfg_t       cfg,
	input  logic       push_ready,
	output logic       push,
	output frame_rec_t push_data
);

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CCMP_W = (COL_W > COORD_W) ? COL_W : COORD_W;
	localparam int RCMP_W = (ROW_W > COORD_W) ? ROW_W : COORD_W;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   csum_q;
	logic [SUM_W-1:0]   rsum_q;

	logic               accept;
	logic [PIX_W-1:0]   diff;
	logic               in_roi;
	logic               moving;
	logic [SUM_W:0]     csum_add;
	logic [SUM_W:0]     rsum_add;
	logic [COUNT_W-1:0] count_nx;
	logic [SUM_W-1:0]   csum_nx;
	logic [SUM_W-1:0]   rsum_nx;

	// only a frame end needs room in the queue
	assign pix_ready = !pix.end_of_frame || push_ready;
	assign accept    = pix_valid && pix_ready;

	always_comb begin
		diff = (pix.cur_pixel > pix.prev_pixel) ? pix.cur_pixel - pix.prev_pixel
		                                        : pix.prev_pixel - pix.cur_pixel;
		in_roi = (CCMP_W'(col_q) >= CCMP_W'(cfg.roi_left)) &&
		         (CCMP_W'(col_q) <= CCMP_W'(cfg.roi_right)) &&
		         (RCMP_W'(row_q) >= RCMP_W'(cfg.roi_top)) &&
		         (RCMP_W'(row_q) <= RCMP_W'(cfg.roi_bottom));
		moving = (diff > cfg.diff_threshold) && in_roi;

		csum_add = {1'b0, csum_q} + (SUM_W+1)'(col_q);
		rsum_add = {1'b0, rsum_q} + (SUM_W+1)'(row_q);

		count_nx = count_q;
		csum_nx  = csum_q;
		rsum_nx  = rsum_q;
		if (moving) begin
			if (count_q != '1)
				count_nx = count_q + 1'b1;
			csum_nx = csum_add[SUM_W] ? '1 : csum_add[SUM_W-1:0];
			rsum_nx = rsum_add[SUM_W] ? '1 : rsum_add[SUM_W-1:0];
		end
	end

	assign push              = accept && pix.end_of_frame;
	assign push_data.count   = count_nx;
	assign push_data.col_sum = csum_nx;
	assign push_data.row_sum = rsum_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			count_q <= '0;
			csum_q  <= '0;
			rsum_q  <= '0;
		end else if (accept) begin
			if (pix.end_of_frame) begin
				col_q   <= '0;
				row_q   <= '0;
				count_q <= '0;
				csum_q  <= '0;
				rsum_q  <= '0;
			end else begin
				count_q <= count_nx;
				csum_q  <= csum_nx;
				rsum_q  <= rsum_nx;
				// saturate position on overlong rows and frames
				if (pix.end_of_line) begin
					col_q <= '0;
					if (row_q != ROW_LAST)
						row_q <= row_q + 1'b1;
				end else if (col_q != COL_LAST) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> design/rmms_queue.sv
module rmms_queue import rmms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       push_ready,
	input  frame_rec_t push_data,
	input  logic       pop,
	output logic       pop_valid,
	output frame_rec_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	frame_rec_t       slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = slot_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

>>> design/rmms_back.sv
module rmms_back import rmms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop,
	input  frame_rec_t pop_data,
	input  cfg_t       cfg,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res
);

	localparam int STEP_W = $clog2(COORD_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_W - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_AREA = 3'd1;
	localparam logic [2:0] ST_PROD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [STEP_W-1:0]   step_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [EXT_W-1:0]    w_q;
	logic [EXT_W-1:0]    h_q;
	logic [AREA_W-1:0]   area_q;
	logic [PROD_W-1:0]   prod_q;
	logic [CNT100_W-1:0] cnt100_q;
	logic [COUNT_W-1:0]  xrem_q;
	logic [COUNT_W-1:0]  yrem_q;
	logic [COORD_W-1:0]  xlo_q;
	logic [COORD_W-1:0]  ylo_q;
	logic [COORD_W-1:0]  xquo_q;
	logic [COORD_W-1:0]  yquo_q;
	logic                xovf_q;
	logic                yovf_q;
	res_t                res_q;
	logic                res_valid_q;

	logic [EXT_W-1:0]   width;
	logic [EXT_W-1:0]   height;
	logic [COUNT_W:0]   xtry;
	logic [COUNT_W:0]   ytry;
	logic [COUNT_W:0]   xsub;
	logic [COUNT_W:0]   ysub;
	logic               xge;
	logic               yge;
	logic               found;
	logic               cvalid;
	res_t               res_nx;

	always_comb begin
		width  = (cfg.roi_right >= cfg.roi_left)
		         ? EXT_W'(cfg.roi_right) - EXT_W'(cfg.roi_left) + 1'b1 : '0;
		height = (cfg.roi_bottom >= cfg.roi_top)
		         ? EXT_W'(cfg.roi_bottom) - EXT_W'(cfg.roi_top) + 1'b1 : '0;

		// one restoring division step per cycle for each axis
		xtry = {xrem_q, xlo_q[COORD_W-1]};
		ytry = {yrem_q, ylo_q[COORD_W-1]};
		xge  = (xtry >= {1'b0, cnt_q});
		yge  = (ytry >= {1'b0, cnt_q});
		xsub = xtry - {1'b0, cnt_q};
		ysub = ytry - {1'b0, cnt_q};

		found  = (prod_q <= PROD_W'(cnt100_q));
		cvalid = found && (cnt_q != '0);
		res_nx.motion_found   = found;
		res_nx.moving_count   = cnt_q;
		res_nx.centroid_x     = cvalid ? (xovf_q ? '1 : xquo_q) : '0;
		res_nx.centroid_y     = cvalid ? (yovf_q ? '1 : yquo_q) : '0;
		res_nx.centroid_valid = cvalid;
	end

	assign pop       = (state_q == ST_IDLE) && pop_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cnt_q    <= pop_data.count;
				w_q      <= width;
				h_q      <= height;
				cnt100_q <= pop_data.count * PERCENT_SCALE;
				// high part at or above the count: mean beyond the coordinate range
				xovf_q   <= pop_data.col_sum[SUM_W-1:COORD_W] >= pop_data.count;
				yovf_q   <= pop_data.row_sum[SUM_W-1:COORD_W] >= pop_data.count;
				xrem_q   <= pop_data.col_sum[SUM_W-1:COORD_W];
				yrem_q   <= pop_data.row_sum[SUM_W-1:COORD_W];
				xlo_q    <= pop_data.col_sum[COORD_W-1:0];
				ylo_q    <= pop_data.row_sum[COORD_W-1:0];
			end
			ST_AREA: area_q <= w_q * h_q;
			ST_PROD: prod_q <= cfg.min_percent * area_q;
			ST_DIV: begin
				xrem_q <= xge ? xsub[COUNT_W-1:0] : xtry[COUNT_W-1:0];
				yrem_q <= yge ? ysub[COUNT_W-1:0] : ytry[COUNT_W-1:0];
				xlo_q  <= xlo_q << 1;
				ylo_q  <= ylo_q << 1;
				xquo_q <= {xquo_q[COORD_W-2:0], xge};
				yquo_q <= {yquo_q[COORD_W-2:0], yge};
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready)
					res_q <= res_nx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!res_valid_q || res_ready))
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid)
						state_q <= ST_AREA;
				end
				ST_AREA: state_q <= ST_PROD;
				ST_PROD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_LAST)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/region_motion_mask_stats.sv
// Pixels: one word per cycle while pix_ready is high; a pixel is folded into the frame sums
// in the cycle it is taken. Frame result: queued, then setup (load, area, product), then an
// 11-step division run in parallel for both centroid axes, then the output register.
// Back end takes a new frame record only from idle; a two-deep queue holds pending frame ends.
// Reset (arst_n low, asynchronous): position, sums, queue and result valid cleared,
// registers back to their defaults; no clearing pass.
module region_motion_mask_stats import rmms_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pix_t                  pix,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t                 cfg_q;
	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;

	logic       q_push;
	logic       q_push_ready;
	frame_rec_t q_push_data;
	logic       q_pop;
	logic       q_pop_valid;
	frame_rec_t q_pop_data;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[REG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.roi_left       <= '0;
			cfg_q.roi_top        <= '0;
			cfg_q.roi_right      <= '1;
			cfg_q.roi_bottom     <= '1;
			cfg_q.diff_threshold <= PIX_W'(25);
			cfg_q.min_percent    <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ROI_LEFT:       cfg_q.roi_left       <= pwdata[COORD_W-1:0];
				REG_ROI_TOP:        cfg_q.roi_top        <= pwdata[COORD_W-1:0];
				REG_ROI_RIGHT:      cfg_q.roi_right      <= pwdata[COORD_W-1:0];
				REG_ROI_BOTTOM:     cfg_q.roi_bottom     <= pwdata[COORD_W-1:0];
				REG_DIFF_THRESHOLD: cfg_q.diff_threshold <= pwdata[PIX_W-1:0];
				REG_MIN_PERCENT:    cfg_q.min_percent    <= pwdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROI_LEFT:       prdata = 32'(cfg_q.roi_left);
			REG_ROI_TOP:        prdata = 32'(cfg_q.roi_top);
			REG_ROI_RIGHT:      prdata = 32'(cfg_q.roi_right);
			REG_ROI_BOTTOM:     prdata = 32'(cfg_q.roi_bottom);
			REG_DIFF_THRESHOLD: prdata = 32'(cfg_q.diff_threshold);
			REG_MIN_PERCENT:    prdata = 32'(cfg_q.min_percent);
			default:            prdata = '0;
		endcase
	end

	rmms_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.cfg       (cfg_q),
		.push_ready(q_push_ready),
		.push      (q_push),
		.push_data (q_push_data)
	);

	rmms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_ready(q_push_ready),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_valid (q_pop_valid),
		.pop_data  (q_pop_data)
	);

	rmms_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(q_pop_valid),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_push_ready)
		else $error("frame record pushed into a full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_pop_valid)
		else $error("back end popped an empty queue");

	a_centroid_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.centroid_valid) |-> (res.motion_found && res.moving_count != '0))
		else $error("centroid flagged valid without motion or moving pixels");

	a_centroid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.centroid_valid) |-> (res.centroid_x == '0 && res.centroid_y == '0))
		else $error("centroid not zero while flagged invalid");

endmodule

>>> tb/sv/tb_region_motion_mask_stats.sv
module tb_region_motion_mask_stats;
	import rmms_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PIXELS = 1000;
	localparam int SETTLE_CYCLES = 24;

	class frame_motion_tracker;
		logic [COORD_W-1:0] roi_left, roi_top, roi_right, roi_bottom;
		logic [PIX_W-1:0]   diff_threshold;
		logic [PCT_W-1:0]   min_percent;
		logic [COORD_W-1:0] col, row;
		logic [COUNT_W-1:0] moving;
		logic [SUM_W-1:0]   col_sum, row_sum;
		res_t expected_frames[$];
		int mismatches;
		int frames_seen;
		int motion_frames;
		int pixels_seen;

		function new();
			roi_left = '0;
			roi_top = '0;
			roi_right = '1;
			roi_bottom = '1;
			diff_threshold = 8'd25;
			min_percent = '0;
			col = '0;
			row = '0;
			moving = '0;
			col_sum = '0;
			row_sum = '0;
			mismatches = 0;
			frames_seen = 0;
			motion_frames = 0;
			pixels_seen = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
			REG_ROI_LEFT:       roi_left = value[COORD_W-1:0];
			REG_ROI_TOP:        roi_top = value[COORD_W-1:0];
			REG_ROI_RIGHT:      roi_right = value[COORD_W-1:0];
			REG_ROI_BOTTOM:     roi_bottom = value[COORD_W-1:0];
			REG_DIFF_THRESHOLD: diff_threshold = value[PIX_W-1:0];
			REG_MIN_PERCENT:    min_percent = value[PCT_W-1:0];
			default: ;
			endcase
		endfunction

		function logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] acc, logic [COORD_W-1:0] v);
			logic [SUM_W:0] s;
			s = acc + v;
			return s[SUM_W] ? '1 : s[SUM_W-1:0];
		endfunction

		function logic [COORD_W-1:0] mean_pos(logic [SUM_W-1:0] sum, logic [COUNT_W-1:0] n);
			logic [SUM_W-1:0] q;
			q = sum / n;
			return (q > 2047) ? '1 : q[COORD_W-1:0];
		endfunction

		function void take_pixel(pix_t p);
			logic [PIX_W-1:0] diff;
			longint area;
			res_t r;
			pixels_seen++;
			diff = (p.cur_pixel > p.prev_pixel) ? p.cur_pixel - p.prev_pixel
				: p.prev_pixel - p.cur_pixel;
			if (diff > diff_threshold && col >= roi_left && col <= roi_right &&
				row >= roi_top && row <= roi_bottom) begin
				if (moving != '1)
					moving++;
				col_sum = sum_sat(col_sum, col);
				row_sum = sum_sat(row_sum, row);
			end
			if (p.end_of_frame) begin
				area = 0;
				// empty rectangle when either edge pair is inverted
				if (roi_right >= roi_left && roi_bottom >= roi_top)
					area = (longint'(roi_right) - longint'(roi_left) + 1) *
						(longint'(roi_bottom) - longint'(roi_top) + 1);
				r.motion_found = longint'(min_percent) * area <= longint'(moving) * 100;
				r.moving_count = moving;
				r.centroid_valid = r.motion_found && moving != 0;
				r.centroid_x = r.centroid_valid ? mean_pos(col_sum, moving) : '0;
				r.centroid_y = r.centroid_valid ? mean_pos(row_sum, moving) : '0;
				expected_frames.push_back(r);
				col = '0;
				row = '0;
				moving = '0;
				col_sum = '0;
				row_sum = '0;
			end else if (p.end_of_line) begin
				col = '0;
				if (row + 1 < MAX_ROWS_DEF)
					row++;
			end else if (col + 1 < MAX_COLS_DEF) begin
				col++;
			end
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void compare_frame(res_t got);
			res_t want;
			if (expected_frames.size() == 0) begin
				$error("frame result with no frame end pending");
				mismatches++;
				return;
			end
			want = expected_frames.pop_front();
			frames_seen++;
			if (want.motion_found)
				motion_frames++;
			check_field("motion_found", want.motion_found, got.motion_found);
			check_field("moving_count", want.moving_count, got.moving_count);
			check_field("centroid_x", want.centroid_x, got.centroid_x);
			check_field("centroid_y", want.centroid_y, got.centroid_y);
			check_field("centroid_valid", want.centroid_valid, got.centroid_valid);
		endfunction

		function void check_leftovers();
			if (expected_frames.size() != 0) begin
				$error("%0d frame results never arrived", expected_frames.size());
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_t                  pix = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_t                  res;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [REG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	bit stall_on = 1'b1;
	frame_motion_tracker tracker;

	region_motion_mask_stats dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix(pix),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	always @(negedge clk) begin
		res_ready <= !(stall_on && $urandom_range(99) < 27);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			tracker.compare_frame(res);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic pix_t pixel(int prev_v, int cur_v, bit eol, bit eof);
		pix_t p;
		p.prev_pixel = prev_v[PIX_W-1:0];
		p.cur_pixel = cur_v[PIX_W-1:0];
		p.end_of_line = eol;
		p.end_of_frame = eof;
		return p;
	endfunction

	// mix of unrelated values, differences close to the threshold and still pixels
	function automatic pix_t random_pixel(logic [PIX_W-1:0] thr);
		int prev_v, cur_v, d;
		prev_v = $urandom_range(255);
		case ($urandom_range(2))
		0: cur_v = $urandom_range(255);
		1: begin
			d = int'(thr) - 1 + $urandom_range(2);
			if (d < 0)
				d = 0;
			if ($urandom_range(1) && prev_v + d <= 255)
				cur_v = prev_v + d;
			else if (prev_v >= d)
				cur_v = prev_v - d;
			else
				cur_v = $urandom_range(255);
		end
		default: cur_v = prev_v;
		endcase
		return pixel(prev_v, cur_v, 1'b0, 1'b0);
	endfunction

	task automatic send_pixel(pix_t p);
		@(negedge clk);
		while (stall_on && $urandom_range(99) < 27) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (!pix_ready);
		tracker.take_pixel(p);
	endtask

	task automatic send_frame(int cols, int rows, bit ragged);
		pix_t p;
		int total;
		total = cols * rows;
		for (int i = 0; i < total; i++) begin
			p = random_pixel(tracker.diff_threshold);
			p.end_of_line = ragged ? ($urandom_range(4) == 0) : ((i % cols) == cols - 1);
			p.end_of_frame = (i == total - 1);
			// frame end also closes the row, with or without the line flag
			if (p.end_of_frame && $urandom_range(3) == 0)
				p.end_of_line = 1'b0;
			send_pixel(p);
		end
	endtask

	// drop valid and let the frame back end run dry before touching registers
	task automatic drain();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (tracker.expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_settings(int l, int t, int r, int b, int thr, int pct);
		drain();
		write_reg(REG_ROI_LEFT, l);
		write_reg(REG_ROI_TOP, t);
		write_reg(REG_ROI_RIGHT, r);
		write_reg(REG_ROI_BOTTOM, b);
		write_reg(REG_DIFF_THRESHOLD, thr);
		write_reg(REG_MIN_PERCENT, pct);
	endtask

	task automatic random_settings();
		int l, t, r, b, thr, pct;
		if ($urandom_range(4) == 0) begin
			l = 0;
			t = 0;
			r = 2047;
			b = 2047;
		end else begin
			l = $urandom_range(6);
			t = $urandom_range(4);
			r = $urandom_range(11);
			b = $urandom_range(7);
		end
		case ($urandom_range(5))
		0: thr = 0;
		1: thr = 255;
		2: thr = $urandom_range(255);
		default: thr = $urandom_range(10, 60);
		endcase
		case ($urandom_range(4))
		0: pct = 0;
		1: pct = 100;
		2: pct = 127;
		default: pct = $urandom_range(100);
		endcase
		apply_settings(l, t, r, b, thr, pct);
	endtask

	initial begin
		int phase;
		int start_count;
		tracker = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// registers at reset values: full-scale rectangle larger than the frame
		send_pixel(pixel(0, 255, 1'b0, 1'b0));
		send_pixel(pixel(255, 0, 1'b0, 1'b0));
		send_pixel(pixel(100, 100, 1'b1, 1'b0));
		send_pixel(pixel(50, 75, 1'b0, 1'b0));
		send_pixel(pixel(50, 76, 1'b0, 1'b0));
		send_pixel(pixel(76, 50, 1'b1, 1'b0));
		send_pixel(pixel(0, 0, 1'b0, 1'b1));
		// still single-pixel frame: no centroid
		send_pixel(pixel(128, 128, 1'b1, 1'b1));

		// inverted columns, zero threshold, percent above 100
		apply_settings(5, 0, 4, 2047, 0, 127);
		send_pixel(pixel(1, 2, 1'b0, 1'b0));
		send_pixel(pixel(3, 4, 1'b0, 1'b0));
		send_pixel(pixel(5, 6, 1'b0, 1'b1));

		// maximum threshold: nothing moves, motion not found
		apply_settings(0, 0, 1, 1, 255, 100);
		send_pixel(pixel(0, 255, 1'b0, 1'b0));
		send_pixel(pixel(255, 0, 1'b1, 1'b0));
		send_pixel(pixel(0, 255, 1'b0, 1'b1));

		// three of four moving below a full-share demand
		apply_settings(0, 0, 1, 1, 254, 100);
		send_pixel(pixel(0, 255, 1'b0, 1'b0));
		send_pixel(pixel(255, 0, 1'b1, 1'b0));
		send_pixel(pixel(7, 7, 1'b0, 1'b0));
		send_pixel(pixel(0, 255, 1'b1, 1'b1));

		start_count = tracker.pixels_seen;
		phase = 0;
		while (tracker.pixels_seen < start_count + RANDOM_PIXELS) begin
			stall_on = !(phase == 3 || phase == 4);
			random_settings();
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(4) == 0)
					send_frame(1, 1, 1'b0);
				else
					send_frame($urandom_range(1, 10), $urandom_range(1, 6),
						$urandom_range(3) == 0);
			end
			phase++;
		end
		stall_on = 1'b1;
		drain();

		tracker.check_leftovers();
		$display("sent %0d pixels in %0d frames, %0d of them flagged motion",
			tracker.pixels_seen, tracker.frames_seen, tracker.motion_frames);
		$display("register sets: %0d random plus directed reset, inverted and threshold cases",
			phase);
		if (tracker.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
